// File: design/tree_lca_binary_lifting_defines.svh
// Assertion macros shared by the lowest common ancestor engine.
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tlca_pkg.sv
`default_nettype none

package tlca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 11;
    localparam int DIST_W  = 11;

    localparam logic [DEPTH_W-1:0] DEPTH_NONE = 11'h7FF;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 11'd2046;
    localparam logic [DIST_W-1:0]  DIST_MAX   = 11'd2046;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_LCA    = 2'd2;
    localparam logic [1:0] OP_ONPATH = 2'd3;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_UNLOAD = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_c;
        logic              has_parent;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] lca_node;
        logic [DIST_W-1:0] distance;
        logic              on_path;
        logic [1:0]        status;
    } out_item_t;

    // One ancestor table entry; valid low means no ancestor.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } anc_entry_t;

endpackage

`default_nettype wire

// File: design/tree_lca_binary_lifting.sv
// Channel  | Signals                      | Transaction
// input    | in_valid, in_ready, in_data  | one operation (load, build, query, on-path)
// output   | out_valid, out_ready, out_data | one result per input transaction
// config   | cfg_we, cfg_data             | node_count write, no wait
//
// After reset a clearing pass over all MAX_NODES entries marks every depth unloaded and every
// ancestor absent; in_ready stays low meanwhile.
// A load with a parent reads the parent depth before it writes; a build walks every node
// once per level over LEVELS-1 levels.
// A query reads the depths of its nodes, climbs once, reads the depth of the ancestor and
// then outputs; an on-path test climbs three times. A result held back by out_ready
// stalls the sequencer in S_OUT.
`default_nettype none

`include "tree_lca_binary_lifting_defines.svh"

module tree_lca_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tlca_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tlca_pkg::out_item_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic [10:0]          cfg_data
);

    import tlca_pkg::*;

    localparam int AW    = $clog2(MAX_NODES);
    localparam int LCW   = $clog2(LEVELS + 1);
    localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_W = $bits(anc_entry_t);
    localparam logic [16:0] MAXN = 17'(MAX_NODES);

    // Which node pair the climb is working on.
    localparam logic [1:0] CALL_AB = 2'd0;
    localparam logic [1:0] CALL_AC = 2'd1;
    localparam logic [1:0] CALL_CB = 2'd2;

    typedef enum logic [23:0] {
        S_CLEAR    = 24'h000001,
        S_IDLE     = 24'h000002,
        S_LD_RD    = 24'h000004,
        S_LD_WT    = 24'h000008,
        S_DEP_A    = 24'h000010,
        S_DEP_B    = 24'h000020,
        S_DEP_C    = 24'h000040,
        S_DEP_CHK  = 24'h000080,
        S_PL_START = 24'h000100,
        S_LIFT     = 24'h000200,
        S_LIFT_WT  = 24'h000400,
        S_EQ       = 24'h000800,
        S_CL_U     = 24'h001000,
        S_CL_V     = 24'h002000,
        S_CL_CMP   = 24'h004000,
        S_FIN_U    = 24'h008000,
        S_FIN_V    = 24'h010000,
        S_FIN_CMP  = 24'h020000,
        S_DIST_RD  = 24'h040000,
        S_DIST     = 24'h080000,
        S_BLD_CHK  = 24'h100000,
        S_BLD_T    = 24'h200000,
        S_BLD_R    = 24'h400000,
        S_OUT      = 24'h800000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [DEPTH_W-1:0]  node_count_reg;

    in_item_t            item_reg, item_next;
    logic [DEPTH_W-1:0]  da_reg, da_next, db_reg, db_next, dc_reg, dc_next;
    logic [DEPTH_W-1:0]  du_reg, du_next, dv_reg, dv_next, diff_reg, diff_next;
    logic [1:0]          call_reg, call_next;
    logic [NODE_W-1:0]   u_reg, u_next, v_reg, v_next, lca_reg, lca_next;
    logic [NODE_W-1:0]   lab_reg, lab_next;
    logic [LCW-1:0]      lvl_reg, lvl_next;
    anc_entry_t          pu_reg, pu_next;
    logic signed [13:0]  dist_reg, dist_next, d1_reg, d1_next;
    logic [DEPTH_W-1:0]  bn_reg, bn_next;
    logic [1:0]          status_reg, status_next;
    logic                onp_reg, onp_next;
    out_item_t           out_reg, out_next;

    // Memory ports.
    logic                dep_we;
    logic [AW-1:0]       dep_waddr, dep_raddr;
    logic [DEPTH_W-1:0]  dep_wdata, dep_rdata;
    logic [LEVELS-1:0]   anc_we;
    logic [AW-1:0]       anc_waddr, anc_raddr;
    anc_entry_t          anc_wdata;
    logic [ANC_W-1:0]    anc_rd_raw [LEVELS];
    anc_entry_t          anc_rd [LEVELS];

    logic [DEPTH_W-1:0]  lim;
    logic [LIW-1:0]      lvl_idx;
    logic [LEVELS-1:0]   diff_lift;
    anc_entry_t          anc_cur;
    logic                bld_we;
    logic [LCW-1:0]      bld_lvl;
    logic [13:0]         dist_raw;
    logic signed [14:0]  dsum;

    // Node limit: the smaller of node_count and the table size.
    assign lim = (17'(node_count_reg) < MAXN) ? node_count_reg : DEPTH_W'(MAX_NODES);

    assign lvl_idx   = lvl_reg[LIW-1:0];
    assign diff_lift = LEVELS'(diff_reg);
    assign anc_cur   = anc_rd[lvl_idx];
    assign bld_lvl   = lvl_reg + LCW'(1);
    assign dist_raw  = {3'b000, du_reg} + {3'b000, dv_reg} - {2'b00, dep_rdata, 1'b0};
    assign dsum      = 15'(d1_reg) + 15'($signed(dist_raw));

    // Depth store.
    tlca_ram #(
        .WIDTH(DEPTH_W),
        .DEPTH(MAX_NODES)
    ) u_depth_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    // One ancestor memory per lifting level, all read at a shared address.
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        tlca_ram #(
            .WIDTH(ANC_W),
            .DEPTH(MAX_NODES)
        ) u_anc_ram (
            .clk   (clk),
            .we    (anc_we[g]),
            .waddr (anc_waddr),
            .wdata (anc_wdata),
            .raddr (anc_raddr),
            .rdata (anc_rd_raw[g])
        );
        assign anc_rd[g] = anc_entry_t'(anc_rd_raw[g]);
        assign anc_we[g] = (state_reg == S_CLEAR)
                        || (bld_we && (LCW'(g) == bld_lvl))
                        || (g == 0 && state_reg == S_IDLE && in_valid
                            && in_data.op == OP_LOAD && !in_data.has_parent
                            && {1'b0, in_data.node_a} < lim)
                        || (g == 0 && state_reg == S_LD_WT && dep_rdata != DEPTH_NONE);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer and datapath.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        dc_next        = dc_reg;
        du_next        = du_reg;
        dv_next        = dv_reg;
        diff_next      = diff_reg;
        call_next      = call_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        lca_next       = lca_reg;
        lab_next       = lab_reg;
        lvl_next       = lvl_reg;
        pu_next        = pu_reg;
        dist_next      = dist_reg;
        d1_next        = d1_reg;
        bn_next        = bn_reg;
        status_next    = status_reg;
        onp_next       = onp_reg;
        out_next       = out_reg;
        dep_we         = 1'b0;
        dep_waddr      = AW'(item_reg.node_a);
        dep_wdata      = DEPTH_NONE;
        dep_raddr      = '0;
        anc_waddr      = AW'(item_reg.node_a);
        anc_wdata      = '0;
        anc_raddr      = '0;
        bld_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                dep_we    = 1'b1;
                dep_waddr = clr_reg;
                anc_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                dep_waddr = AW'(in_data.node_a);
                anc_waddr = AW'(in_data.node_a);
                dep_wdata = '0;
                if (in_valid)
                begin
                    item_next   = in_data;
                    status_next = ST_OK;
                    lca_next    = '0;
                    lab_next    = '0;
                    dist_next   = '0;
                    onp_next    = 1'b0;
                    unique case (in_data.op)
                        OP_LOAD:
                        begin
                            if ({1'b0, in_data.node_a} >= lim
                                || (in_data.has_parent && {1'b0, in_data.node_b} >= lim))
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_OUT;
                            end
                            else if (in_data.has_parent)
                            begin
                                state_next = S_LD_RD;
                            end
                            else
                            begin
                                // A root: depth zero, no ancestor.
                                dep_we     = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        OP_BUILD:
                        begin
                            lvl_next   = '0;
                            bn_next    = '0;
                            state_next = S_BLD_CHK;
                        end
                        default:
                        begin
                            if ({1'b0, in_data.node_a} >= lim || {1'b0, in_data.node_b} >= lim
                                || (in_data.op == OP_ONPATH && {1'b0, in_data.node_c} >= lim))
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_DEP_A;
                            end
                        end
                    endcase
                end
            end
            S_LD_RD:
            begin
                dep_raddr  = AW'(item_reg.node_b);
                state_next = S_LD_WT;
            end
            S_LD_WT:
            begin
                // Child depth is parent depth plus one, saturated.
                if (dep_rdata == DEPTH_NONE)
                begin
                    status_next = ST_UNLOAD;
                end
                else
                begin
                    dep_we    = 1'b1;
                    dep_wdata = (dep_rdata >= DEPTH_MAX) ? DEPTH_MAX
                                                         : dep_rdata + DEPTH_W'(1);
                    anc_wdata = '{valid: 1'b1, node: item_reg.node_b};
                end
                state_next = S_OUT;
            end
            S_DEP_A:
            begin
                dep_raddr  = AW'(item_reg.node_a);
                state_next = S_DEP_B;
            end
            S_DEP_B:
            begin
                da_next    = dep_rdata;
                dep_raddr  = AW'(item_reg.node_b);
                state_next = S_DEP_C;
            end
            S_DEP_C:
            begin
                db_next    = dep_rdata;
                dep_raddr  = AW'(item_reg.node_c);
                state_next = S_DEP_CHK;
            end
            S_DEP_CHK:
            begin
                dc_next = dep_rdata;
                if (da_reg == DEPTH_NONE || db_reg == DEPTH_NONE
                    || (item_reg.op == OP_ONPATH && dep_rdata == DEPTH_NONE))
                begin
                    status_next = ST_UNLOAD;
                    state_next  = S_OUT;
                end
                else
                begin
                    call_next  = CALL_AB;
                    state_next = S_PL_START;
                end
            end
            S_PL_START:
            begin
                logic [NODE_W-1:0]  x, y;
                logic [DEPTH_W-1:0] dx, dy;
                unique case (call_reg)
                    CALL_AC:
                    begin
                        x = item_reg.node_a;  y = item_reg.node_c;
                        dx = da_reg;          dy = dc_reg;
                    end
                    CALL_CB:
                    begin
                        x = item_reg.node_c;  y = item_reg.node_b;
                        dx = dc_reg;          dy = db_reg;
                    end
                    default:
                    begin
                        x = item_reg.node_a;  y = item_reg.node_b;
                        dx = da_reg;          dy = db_reg;
                    end
                endcase
                du_next = dx;
                dv_next = dy;
                // The deeper node climbs first.
                if (dx < dy)
                begin
                    u_next    = y;
                    v_next    = x;
                    diff_next = dy - dx;
                end
                else
                begin
                    u_next    = x;
                    v_next    = y;
                    diff_next = dx - dy;
                end
                lvl_next   = '0;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                anc_raddr = AW'(u_reg);
                if (lvl_reg == LCW'(LEVELS))
                begin
                    state_next = S_EQ;
                end
                else if (diff_lift[lvl_idx])
                begin
                    state_next = S_LIFT_WT;
                end
                else
                begin
                    lvl_next = lvl_reg + LCW'(1);
                end
            end
            S_LIFT_WT:
            begin
                if (anc_cur.valid)
                begin
                    u_next = anc_cur.node;
                end
                lvl_next   = lvl_reg + LCW'(1);
                state_next = S_LIFT;
            end
            S_EQ:
            begin
                if (u_reg == v_reg)
                begin
                    lca_next   = u_reg;
                    state_next = S_DIST_RD;
                end
                else
                begin
                    lvl_next   = LCW'(LEVELS - 1);
                    state_next = S_CL_U;
                end
            end
            S_CL_U:
            begin
                anc_raddr  = AW'(u_reg);
                state_next = S_CL_V;
            end
            S_CL_V:
            begin
                pu_next    = anc_cur;
                anc_raddr  = AW'(v_reg);
                state_next = S_CL_CMP;
            end
            S_CL_CMP:
            begin
                // Both climb together only while their ancestors differ.
                if (pu_reg.valid && anc_cur.valid && pu_reg.node != anc_cur.node)
                begin
                    u_next = pu_reg.node;
                    v_next = anc_cur.node;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN_U;
                end
                else
                begin
                    lvl_next   = lvl_reg - LCW'(1);
                    state_next = S_CL_U;
                end
            end
            S_FIN_U:
            begin
                anc_raddr  = AW'(u_reg);
                state_next = S_FIN_V;
            end
            S_FIN_V:
            begin
                pu_next    = anc_rd[0];
                anc_raddr  = AW'(v_reg);
                state_next = S_FIN_CMP;
            end
            S_FIN_CMP:
            begin
                if (!pu_reg.valid || !anc_rd[0].valid || pu_reg.node != anc_rd[0].node)
                begin
                    status_next = ST_UNLOAD;
                    state_next  = S_OUT;
                end
                else
                begin
                    lca_next   = pu_reg.node;
                    state_next = S_DIST_RD;
                end
            end
            S_DIST_RD:
            begin
                dep_raddr  = AW'(lca_reg);
                state_next = S_DIST;
            end
            S_DIST:
            begin
                unique case (call_reg)
                    CALL_AC:
                    begin
                        d1_next    = $signed(dist_raw);
                        call_next  = CALL_CB;
                        state_next = S_PL_START;
                    end
                    CALL_CB:
                    begin
                        onp_next   = (15'(dist_reg) == dsum);
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        // The answer is the ancestor of the a-b pair.
                        lab_next  = lca_reg;
                        dist_next = $signed(dist_raw);
                        if (item_reg.op == OP_ONPATH)
                        begin
                            call_next  = CALL_AC;
                            state_next = S_PL_START;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                endcase
            end
            S_BLD_CHK:
            begin
                anc_raddr = AW'(bn_reg);
                if (lvl_reg >= LCW'(LEVELS - 1))
                begin
                    state_next = S_OUT;
                end
                else if (bn_reg >= lim)
                begin
                    bn_next  = '0;
                    lvl_next = lvl_reg + LCW'(1);
                end
                else
                begin
                    state_next = S_BLD_T;
                end
            end
            S_BLD_T:
            begin
                anc_waddr = AW'(bn_reg);
                anc_raddr = AW'(anc_cur.node);
                if (anc_cur.valid)
                begin
                    state_next = S_BLD_R;
                end
                else
                begin
                    bld_we     = 1'b1;
                    bn_next    = bn_reg + DEPTH_W'(1);
                    state_next = S_BLD_CHK;
                end
            end
            S_BLD_R:
            begin
                // Next level: the ancestor of the ancestor.
                anc_waddr  = AW'(bn_reg);
                anc_wdata  = anc_cur;
                bld_we     = 1'b1;
                bn_next    = bn_reg + DEPTH_W'(1);
                state_next = S_BLD_CHK;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (status_reg != ST_OK)
                    begin
                        out_next = '{lca_node: '0, distance: '0, on_path: 1'b0,
                                     status: status_reg};
                    end
                    else
                    begin
                        out_next.lca_node = lab_reg;
                        out_next.on_path  = onp_reg;
                        out_next.status   = ST_OK;
                        if (dist_reg < 0)
                        begin
                            out_next.distance = '0;
                        end
                        else if (dist_reg > $signed({3'b000, DIST_MAX}))
                        begin
                            out_next.distance = DIST_MAX;
                        end
                        else
                        begin
                            out_next.distance = DIST_W'(dist_reg);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            node_count_reg <= DEPTH_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        dc_reg     <= dc_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        diff_reg   <= diff_next;
        call_reg   <= call_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        lca_reg    <= lca_next;
        lab_reg    <= lab_next;
        lvl_reg    <= lvl_next;
        pu_reg     <= pu_next;
        dist_reg   <= dist_next;
        d1_reg     <= d1_next;
        bn_reg     <= bn_next;
        status_reg <= status_next;
        onp_reg    <= onp_next;
        out_reg    <= out_next;
    end

    `TLCA_ASSERT_NOW(a_no_take_in_clear, state_reg == S_CLEAR, !in_ready,
        "transaction taken during the clearing pass")
    `TLCA_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready,
        "input ready right after a transaction was taken")
    `TLCA_ASSERT_NOW(a_error_zero_fields, out_valid && out_data.status != ST_OK,
        out_data.lca_node == '0 && out_data.distance == '0 && !out_data.on_path,
        "error result carries nonzero fields")
    `TLCA_ASSERT_NOW(a_dist_clamped, out_valid, out_data.distance <= DIST_MAX,
        "distance beyond its clamp")

endmodule

`default_nettype wire

// File: design/tlca_ram.sv
`default_nettype none

module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: test/tlca_checker.sv
import tlca_pkg::*;

module tlca_checker (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data,
    input  wire logic      cfg_we,
    input  wire logic [10:0] cfg_data,
    output int             fail_count,
    output int             pending
);
    localparam int NODES = 1024;
    localparam int LVLS  = 10;

    // Shadow copy of the tree state.
    logic [10:0]  count_reg;
    logic [10:0]  depth_of [NODES];
    anc_entry_t   anc_of [LVLS][NODES];
    out_item_t    expected_results [$];

    function automatic anc_entry_t lift(int lvl, anc_entry_t n);
        anc_entry_t none;
        none = '0;
        if (!n.valid) return none;
        return anc_of[lvl][n.node];
    endfunction

    // Binary lifting search; returns 0 when no common ancestor exists.
    function automatic bit common_ancestor(int u, int v, output int res);
        int du, dv, t, diff;
        anc_entry_t pu, pv;
        du = depth_of[u];
        dv = depth_of[v];
        if (du < dv)
        begin
            t = u; u = v; v = t;
            t = du; du = dv; dv = t;
        end
        diff = du - dv;
        for (int i = 0; i < LVLS; i++)
        begin
            if (diff[i])
            begin
                pu = anc_of[i][u];
                if (pu.valid) u = pu.node;
            end
        end
        if (u == v)
        begin
            res = u;
            return 1;
        end
        for (int i = LVLS - 1; i >= 0; i--)
        begin
            pu = anc_of[i][u];
            pv = anc_of[i][v];
            if (pu.valid && pv.valid && pu.node != pv.node)
            begin
                u = pu.node;
                v = pv.node;
            end
        end
        pu = anc_of[0][u];
        pv = anc_of[0][v];
        if (!pu.valid || !pv.valid || pu.node != pv.node) return 0;
        res = pu.node;
        return 1;
    endfunction

    function automatic bit path_edges(int u, int v, output int d, output int l);
        if (!common_ancestor(u, v, l)) return 0;
        d = int'(depth_of[u]) + int'(depth_of[v]) - 2 * int'(depth_of[l]);
        return 1;
    endfunction

    function automatic out_item_t apply_op(in_item_t t);
        out_item_t r;
        int lim, a, b, c, d, d1, d2, l, l2;
        bit three;
        r = '0;
        lim = (count_reg < NODES) ? count_reg : NODES;
        a = t.node_a;
        b = t.node_b;
        c = t.node_c;
        d = 0;
        case (t.op)
            OP_LOAD:
            begin
                if (a >= lim || (t.has_parent && b >= lim)) r.status = ST_RANGE;
                else if (t.has_parent && depth_of[b] == DEPTH_NONE) r.status = ST_UNLOAD;
                else if (t.has_parent)
                begin
                    depth_of[a] = (depth_of[b] >= DEPTH_MAX) ? DEPTH_MAX : depth_of[b] + 1;
                    anc_of[0][a] = '{valid: 1'b1, node: t.node_b};
                end
                else
                begin
                    depth_of[a] = '0;
                    anc_of[0][a] = '0;
                end
            end
            OP_BUILD:
            begin
                for (int i = 0; i + 1 < LVLS; i++)
                    for (int n = 0; n < lim; n++)
                        anc_of[i+1][n] = lift(i, anc_of[i][n]);
            end
            default:
            begin
                three = (t.op == OP_ONPATH);
                if (a >= lim || b >= lim || (three && c >= lim)) r.status = ST_RANGE;
                else if (depth_of[a] == DEPTH_NONE || depth_of[b] == DEPTH_NONE
                         || (three && depth_of[c] == DEPTH_NONE)) r.status = ST_UNLOAD;
                else if (!path_edges(a, b, d, l)) r.status = ST_UNLOAD;
                else
                begin
                    r.lca_node = l;
                    if (three)
                    begin
                        if (!path_edges(a, c, d1, l2) || !path_edges(c, b, d2, l2))
                            r.status = ST_UNLOAD;
                        else r.on_path = (d == d1 + d2);
                    end
                end
                if (r.status != ST_OK) r = '{lca_node: '0, distance: '0,
                                             on_path: 1'b0, status: r.status};
                else
                begin
                    if (d < 0) d = 0;
                    if (d > DIST_MAX) d = DIST_MAX;
                    r.distance = d;
                end
            end
        endcase
        return r;
    endfunction

    assign pending = expected_results.size();

    // Track configuration, predict accepted transactions, compare results.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            count_reg = 11'd1;
            fail_count = 0;
            expected_results.delete();
            for (int n = 0; n < NODES; n++)
            begin
                depth_of[n] = DEPTH_NONE;
                for (int i = 0; i < LVLS; i++) anc_of[i][n] = '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.lca_node !== out_data.lca_node || want.distance !== out_data.distance
                        || want.on_path !== out_data.on_path || want.status !== out_data.status)
                    begin
                        $display("%0t: expected %p, actual %p", $time, want, out_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), apply_op(in_data));
            if (cfg_we) count_reg = cfg_data;
        end
    end
endmodule

// File: test/tb.sv
import tlca_pkg::*;

module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          hold_long = 0;
    int          counts [6] = '{16, 64, 1024, 40, 8, 200};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tree_lca_binary_lifting dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    tlca_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Offer one transaction, with a random gap before it. Valid drops only for a gap.
    task automatic send(logic [1:0] op, int a, int b, int c, bit hp);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{op: op, node_a: a[9:0], node_b: b[9:0], node_c: c[9:0], has_parent: hp};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_count(int v);
        cfg_we <= 1'b1;
        cfg_data <= v[10:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Load a random tree over nodes below n; root at node 0 plus a few extra roots.
    task automatic load_tree(int n);
        send(OP_LOAD, 0, $urandom_range(0, 1023), 0, 1'b0);
        for (int k = 1; k < n; k++)
        begin
            if ($urandom_range(0, 15) == 0) send(OP_LOAD, k, 0, 0, 1'b0);
            else send(OP_LOAD, k, $urandom_range(0, k - 1), 0, 1'b1);
        end
    endtask

    task automatic queries(int n, int cnt);
        int hi;
        for (int k = 0; k < cnt; k++)
        begin
            hi = ($urandom_range(0, 9) == 0) ? 1023 : n - 1;
            case ($urandom_range(0, 9))
                0: send(OP_LOAD, $urandom_range(0, hi), $urandom_range(0, hi),
                        $urandom, $urandom_range(0, 1));
                1: send(OP_BUILD, $urandom, $urandom, $urandom, $urandom_range(0, 1));
                2, 3, 4: send(OP_LCA, $urandom_range(0, hi), $urandom_range(0, hi),
                              $urandom, $urandom_range(0, 1));
                default: send(OP_ONPATH, $urandom_range(0, hi), $urandom_range(0, hi),
                              $urandom_range(0, hi), $urandom_range(0, 1));
            endcase
        end
    endtask

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 0;
                gap = 3000;
            end
            else
            begin
                gap = gap_len();
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: default count, out-of-range, unloaded, chain.
        send(OP_LCA, 0, 0, 0, 1'b0);
        send(OP_LOAD, 1, 0, 0, 1'b0);
        send(OP_LOAD, 0, 0, 0, 1'b1);
        send(OP_LOAD, 0, 0, 0, 1'b0);
        send(OP_LCA, 0, 0, 0, 1'b0);
        send(OP_ONPATH, 0, 0, 0, 1'b1);
        send(OP_BUILD, 1023, 1023, 1023, 1'b1);
        drain();
        set_count(2047);
        send(OP_LCA, 5, 1023, 0, 1'b0);
        send(OP_LOAD, 1023, 0, 0, 1'b1);
        send(OP_LOAD, 1022, 1023, 0, 1'b1);
        send(OP_LOAD, 700, 900, 0, 1'b1);
        send(OP_LCA, 1022, 0, 0, 1'b0);
        send(OP_BUILD, 0, 0, 0, 1'b0);
        send(OP_ONPATH, 1022, 0, 1023, 1'b0);
        send(OP_ONPATH, 1022, 1023, 0, 1'b0);
        send(OP_LOAD, 1023, 1023, 0, 1'b0);
        send(OP_LCA, 1022, 0, 0, 1'b0);
        send(OP_LCA, 1022, 1023, 0, 1'b0);
        drain();
        // Random phases across several node counts.
        foreach (counts[p])
        begin
            int n;
            n = counts[p];
            set_count(n);
            if (n == 1024) load_tree(n);
            else
            begin
                load_tree(n);
                send(OP_BUILD, 0, 0, 0, 1'b0);
                if (p == 1) hold_long = 1;
                queries(n, 90);
            end
            if (n == 1024)
            begin
                send(OP_BUILD, 0, 0, 0, 1'b0);
                queries(n, 60);
            end
            drain();
        end
        // Build bounded by count 1 again, then a few queries.
        set_count(1);
        send(OP_BUILD, 0, 0, 0, 1'b0);
        queries(1, 20);
        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
